@@ rtl/light_button_battery_controller_core_defines.svh @@
// Assertion macros used by the light controller checker file.
`ifndef LIGHT_BUTTON_BATTERY_CONTROLLER_CORE_DEFINES_SVH
`define LIGHT_BUTTON_BATTERY_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define LBBC_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("lbbc: same-cycle check failed");

// next-cycle implication
`define LBBC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("lbbc: next-cycle check failed");

`endif

@@ rtl/lbbc_pkg.sv @@
// Types, widths and constants of the light button and battery controller.
`default_nettype none
package lbbc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int VOLT_W      = 12;
    localparam int CUR_W       = 8;
    localparam int DUTY_W      = 10;
    localparam int LEVELS_W    = 24;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int DIV_STEPS   = DUTY_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [VOLT_W-1:0] SAMPLE_MASK  = VOLT_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [VOLT_W-1:0] FILTER_RESET = VOLT_W'(3100) & SAMPLE_MASK;

    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 24'd16744512;
    localparam logic [VOLT_W-1:0]   UV_THR_RESET = 12'd2900;
    localparam logic [VOLT_W-1:0]   UV_REL_RESET = 12'd3100;
    localparam logic [CUR_W-1:0]    UV_CAP_RESET = 8'd32;
    localparam logic [CUR_W-1:0]    LV_CAP_RESET = 8'd128;
    localparam logic [CUR_W-1:0]    LONG_RESET   = 8'd50;
    localparam logic [VOLT_W-1:0]   EMPTY_RESET  = 12'd3000;
    localparam logic [VOLT_W-1:0]   FULL_RESET   = 12'd3600;

    localparam logic [CUR_W-1:0]  CUR_MAX    = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_FULL  = 10'd1023;
    localparam logic [DUTY_W-1:0] DUTY_FAULT = 10'd511;

    localparam logic [2:0] REG_LEVELS = 3'd0;
    localparam logic [2:0] REG_UV_THR = 3'd1;
    localparam logic [2:0] REG_UV_REL = 3'd2;
    localparam logic [2:0] REG_UV_CAP = 3'd3;
    localparam logic [2:0] REG_LV_CAP = 3'd4;
    localparam logic [2:0] REG_LONG   = 3'd5;
    localparam logic [2:0] REG_EMPTY  = 3'd6;
    localparam logic [2:0] REG_FULL   = 3'd7;

    typedef enum logic [2:0] {
        UI_SLEEP     = 3'd0,
        UI_WAKE      = 3'd1,
        UI_WAKE_WAIT = 3'd2,
        UI_ON        = 3'd3,
        UI_PRESSED   = 3'd4
    } ui_state_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_CALC,
        CTL_DIV,
        CTL_DONE
    } ctl_state_t;

endpackage
`default_nettype wire

@@ rtl/light_button_battery_controller_core.sv @@
// Light controller top level: button UI, battery filter, current cap and LED gauge.
//
// Usage: one item per UI tick on the input channel (in_valid/in_ready):
// button_released, battery_sample, fault. Each item gives exactly one result
// on the output channel (out_valid/out_ready): sleep_req, drive_req,
// led_off, led_duty. The user must write registers over the APB port only
// while idle; the block itself does not enforce this. The item is taken into
// the input registers, the UI, filter and cap logic work on it and write the
// result registers, and the output register then takes the result and raises
// out_valid. When the LED shows the battery gauge inside the empty..full span,
// a restoring divider produces the 10 gauge bits one per cycle before the
// output register takes the result. One item is in flight at a time; the next
// is taken once the result sits in the output register.
// If the receiver stalls, the result holds in the output register and the
// next item is still taken and worked; it then waits until the output frees.
// Reset puts the UI in sleep, brightness at level 0, the filter at 3100,
// clears the undervoltage latch and blink counter, and loads register defaults.
`default_nettype none
module light_button_battery_controller_core
    import lbbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              button_released,
    input  wire logic [VOLT_W-1:0] battery_sample,
    input  wire logic              fault,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   sleep_req,
    output logic      [CUR_W-1:0]  drive_req,
    output logic                   led_off,
    output logic      [DUTY_W-1:0] led_duty
);

    logic [LEVELS_W-1:0] levels_reg;
    logic [VOLT_W-1:0]   uv_thr_reg;
    logic [VOLT_W-1:0]   uv_rel_reg;
    logic [CUR_W-1:0]    uv_cap_reg;
    logic [CUR_W-1:0]    lv_cap_reg;
    logic [CUR_W-1:0]    long_reg;
    logic [VOLT_W-1:0]   empty_reg;
    logic [VOLT_W-1:0]   full_reg;
    logic                cfg_wr;
    logic [2:0]          cfg_idx;

    ctl_state_t          ctl_reg, ctl_next;
    ui_state_t           ui_reg, ui_next;
    logic [1:0]          idx_reg, idx_next;
    logic [CUR_W-1:0]    press_reg, press_next;
    logic [VOLT_W-1:0]   filt_reg, filt_next;
    logic                uv_reg, uv_next;
    logic [3:0]          blink_reg, blink_next;

    logic                rel_reg, rel_next;
    logic [VOLT_W-1:0]   sample_reg, sample_next;
    logic                fault_reg, fault_next;

    logic [VOLT_W-1:0]   rem_reg, rem_next;
    logic [VOLT_W-1:0]   span_reg, span_next;
    logic [DUTY_W-1:0]   quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic                res_sleep_reg, res_sleep_next;
    logic [CUR_W-1:0]    res_cur_reg, res_cur_next;
    logic                res_off_reg, res_off_next;
    logic [DUTY_W-1:0]   res_duty_reg, res_duty_next;

    logic                ov_reg, ov_next;
    logic                o_sleep_reg, o_sleep_next;
    logic [CUR_W-1:0]    o_cur_reg, o_cur_next;
    logic                o_off_reg, o_off_next;
    logic [DUTY_W-1:0]   o_duty_reg, o_duty_next;

    logic [VOLT_W:0]     filt_sum;
    logic [VOLT_W-1:0]   samp_m;
    logic [CUR_W-1:0]    cap;
    logic [CUR_W-1:0]    level;
    logic [VOLT_W:0]     rem2;
    logic                div_ge;
    logic [VOLT_W:0]     rem_sub;
    logic [DUTY_W-1:0]   quo_shift;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_LEVELS: prdata = DATA_W'(levels_reg);
            REG_UV_THR: prdata = DATA_W'(uv_thr_reg);
            REG_UV_REL: prdata = DATA_W'(uv_rel_reg);
            REG_UV_CAP: prdata = DATA_W'(uv_cap_reg);
            REG_LV_CAP: prdata = DATA_W'(lv_cap_reg);
            REG_LONG:   prdata = DATA_W'(long_reg);
            REG_EMPTY:  prdata = DATA_W'(empty_reg);
            REG_FULL:   prdata = DATA_W'(full_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= LEVELS_RESET;
            uv_thr_reg <= UV_THR_RESET;
            uv_rel_reg <= UV_REL_RESET;
            uv_cap_reg <= UV_CAP_RESET;
            lv_cap_reg <= LV_CAP_RESET;
            long_reg   <= LONG_RESET;
            empty_reg  <= EMPTY_RESET;
            full_reg   <= FULL_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_LEVELS: levels_reg <= pwdata[LEVELS_W-1:0];
                REG_UV_THR: uv_thr_reg <= pwdata[VOLT_W-1:0];
                REG_UV_REL: uv_rel_reg <= pwdata[VOLT_W-1:0];
                REG_UV_CAP: uv_cap_reg <= pwdata[CUR_W-1:0];
                REG_LV_CAP: lv_cap_reg <= pwdata[CUR_W-1:0];
                REG_LONG:   long_reg   <= pwdata[CUR_W-1:0];
                REG_EMPTY:  empty_reg  <= pwdata[VOLT_W-1:0];
                REG_FULL:   full_reg   <= pwdata[VOLT_W-1:0];
                default:    ;
            endcase
        end
    end

    // handshake
    assign in_ready   = (ctl_reg == CTL_IDLE);
    assign out_valid  = ov_reg;
    assign sleep_req  = o_sleep_reg;
    assign drive_req  = o_cur_reg;
    assign led_off    = o_off_reg;
    assign led_duty   = o_duty_reg;

    // datapath helpers
    assign samp_m   = battery_sample & SAMPLE_MASK;
    assign filt_sum = {1'b0, filt_reg} - {4'd0, filt_reg[VOLT_W-1:3]}
                      + {4'd0, sample_reg[VOLT_W-1:3]};
    assign rem2      = {rem_reg, 1'b0};
    assign div_ge    = (rem2 >= {1'b0, span_reg});
    assign rem_sub   = rem2 - {1'b0, span_reg};
    assign quo_shift = {quo_reg[DUTY_W-2:0], div_ge};

    always_comb
    begin
        ctl_next       = ctl_reg;
        ui_next        = ui_reg;
        idx_next       = idx_reg;
        press_next     = press_reg;
        filt_next      = filt_reg;
        uv_next        = uv_reg;
        blink_next     = blink_reg;
        rel_next       = rel_reg;
        sample_next    = sample_reg;
        fault_next     = fault_reg;
        rem_next       = rem_reg;
        span_next      = span_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_sleep_next = res_sleep_reg;
        res_cur_next   = res_cur_reg;
        res_off_next   = res_off_reg;
        res_duty_next  = res_duty_reg;
        ov_next        = ov_reg;
        o_sleep_next   = o_sleep_reg;
        o_cur_next     = o_cur_reg;
        o_off_next     = o_off_reg;
        o_duty_next    = o_duty_reg;
        cap            = CUR_MAX;
        level          = levels_reg[7:0];

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (ctl_reg)
            CTL_IDLE:
            begin
                if (in_valid)
                begin
                    rel_next    = button_released;
                    sample_next = samp_m;
                    fault_next  = fault;
                    ctl_next    = CTL_CALC;
                end
            end

            CTL_CALC:
            begin
                // button machine
                unique case (ui_reg)
                    UI_SLEEP:
                    begin
                        if (!rel_reg)
                        begin
                            press_next = '0;
                            ui_next    = UI_WAKE;
                        end
                    end
                    UI_WAKE:
                    begin
                        if (rel_reg)
                            ui_next = UI_SLEEP;
                        else if (press_reg > long_reg)
                            ui_next = UI_WAKE_WAIT;
                        else
                            press_next = press_reg + 1'b1;
                    end
                    UI_WAKE_WAIT:
                    begin
                        if (rel_reg)
                            ui_next = UI_ON;
                    end
                    UI_ON:
                    begin
                        if (!rel_reg)
                        begin
                            ui_next    = UI_PRESSED;
                            press_next = '0;
                        end
                    end
                    UI_PRESSED:
                    begin
                        if (rel_reg)
                        begin
                            idx_next = (idx_reg < 2'd2) ? idx_reg + 1'b1 : 2'd0;
                            ui_next  = UI_ON;
                        end
                        else if (press_reg > long_reg)
                            ui_next = UI_SLEEP;
                        else
                            press_next = press_reg + 1'b1;
                    end
                    default:
                    begin
                        ui_next = UI_SLEEP;
                    end
                endcase

                // battery filter and undervoltage latch
                filt_next = filt_sum[VOLT_W-1:0] & SAMPLE_MASK;
                if (filt_next < uv_thr_reg)
                begin
                    uv_next = 1'b1;
                    cap     = uv_cap_reg;
                end
                else if (uv_reg)
                begin
                    if (filt_next >= uv_rel_reg)
                        uv_next = 1'b0;
                    else
                        cap = uv_cap_reg;
                end
                else if (filt_next < uv_rel_reg)
                begin
                    cap = lv_cap_reg;
                end

                case (idx_next)
                    2'd1:    level = levels_reg[15:8];
                    2'd2:    level = levels_reg[23:16];
                    default: level = levels_reg[7:0];
                endcase

                res_sleep_next = (ui_next == UI_SLEEP);
                res_cur_next   = (level > cap) ? cap : level;
                if (ui_next == UI_SLEEP || ui_next == UI_WAKE)
                    res_cur_next = '0;

                res_off_next  = 1'b0;
                res_duty_next = '0;
                ctl_next      = CTL_DONE;
                rem_next      = filt_next - empty_reg;
                span_next     = full_reg - empty_reg;
                quo_next      = '0;
                cnt_next      = '0;

                if (ui_next == UI_SLEEP)
                begin
                    res_off_next = 1'b1;
                end
                else
                begin
                    if (uv_next || fault_reg)
                    begin
                        if (blink_reg[3])
                            res_off_next = 1'b1;
                        else
                            res_duty_next = fault_reg ? DUTY_FAULT : DUTY_FULL;
                    end
                    else if (filt_next <= empty_reg)
                    begin
                        res_duty_next = DUTY_FULL;
                    end
                    else if (filt_next >= full_reg)
                    begin
                        res_duty_next = '0;
                    end
                    else
                    begin
                        ctl_next = CTL_DIV;
                    end
                    blink_next = blink_reg + 1'b1;
                end
            end

            CTL_DIV:
            begin
                // restoring division, one quotient bit per cycle
                quo_next = quo_shift;
                if (div_ge)
                    rem_next = rem_sub[VOLT_W-1:0];
                else
                    rem_next = rem2[VOLT_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    res_duty_next = ~quo_shift;
                    ctl_next      = CTL_DONE;
                end
            end

            CTL_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next      = 1'b1;
                    o_sleep_next = res_sleep_reg;
                    o_cur_next   = res_cur_reg;
                    o_off_next   = res_off_reg;
                    o_duty_next  = res_duty_reg;
                    ctl_next     = CTL_IDLE;
                end
            end

            default:
            begin
                ctl_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= CTL_IDLE;
            ui_reg    <= UI_SLEEP;
            idx_reg   <= '0;
            press_reg <= '0;
            filt_reg  <= FILTER_RESET;
            uv_reg    <= 1'b0;
            blink_reg <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            ctl_reg   <= ctl_next;
            ui_reg    <= ui_next;
            idx_reg   <= idx_next;
            press_reg <= press_next;
            filt_reg  <= filt_next;
            uv_reg    <= uv_next;
            blink_reg <= blink_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg       <= rel_next;
        sample_reg    <= sample_next;
        fault_reg     <= fault_next;
        rem_reg       <= rem_next;
        span_reg      <= span_next;
        quo_reg       <= quo_next;
        res_sleep_reg <= res_sleep_next;
        res_cur_reg   <= res_cur_next;
        res_off_reg   <= res_off_next;
        res_duty_reg  <= res_duty_next;
        o_sleep_reg   <= o_sleep_next;
        o_cur_reg     <= o_cur_next;
        o_off_reg     <= o_off_next;
        o_duty_reg    <= o_duty_next;
    end

endmodule
`default_nettype wire

@@ rtl/lbbc_checker.sv @@
// Port-level checker for the light controller, bound to the top level.
`default_nettype none
`include "light_button_battery_controller_core_defines.svh"
module lbbc_checker
    import lbbc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              sleep_req,
    input wire logic [CUR_W-1:0]  drive_req,
    input wire logic              led_off,
    input wire logic [DUTY_W-1:0] led_duty
);

    logic [CUR_W+DUTY_W+1:0] out_word;

    assign out_word = {sleep_req, drive_req, led_off, led_duty};

    `LBBC_ASSERT_NOW(a_sleep_dark, clk, rst_n, out_valid && sleep_req, drive_req == '0 && led_off)
    `LBBC_ASSERT_NOW(a_off_no_duty, clk, rst_n, out_valid && led_off, led_duty == '0)
    `LBBC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
    `LBBC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

bind light_button_battery_controller_core lbbc_checker u_lbbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sleep_req (sleep_req),
    .drive_req (drive_req),
    .led_off   (led_off),
    .led_duty  (led_duty)
);
`default_nettype wire
